@@ rtl/tbim_pkg.sv @@
// Shared types, constants and a helper function for the tensor border index map.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package tbim_pkg;

  localparam int NUM_DIMS   = 3;
  localparam int MAX_EXTENT = 4096;
  localparam int DIM_SLOTS  = 3;

  localparam int COORD_W    = 14;
  localparam int SIZE_W     = 13;
  localparam int BORDER_W   = 12;
  localparam int SRC_W      = 12;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam int EXT_W  = $clog2(MAX_EXTENT + 1);
  localparam int POS_W  = COORD_W + 1;
  localparam int VAL_W  = ((POS_W > EXT_W + 1) ? POS_W : EXT_W + 1) + 1;
  localparam int MAG_W  = COORD_W;
  localparam int REM_W  = MAG_W + EXT_W;
  localparam int CORR_W = (MAG_W > EXT_W) ? MAG_W : EXT_W;
  localparam int STEPS  = MAG_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_ZERO,
    MODE_CYCLIC,
    MODE_REPLICATE,
    MODE_REFLECT
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BORDER_MODE,
    REG_SIZE_DIM0,
    REG_SIZE_DIM1,
    REG_SIZE_DIM2,
    REG_BORDER_DIM0,
    REG_BORDER_DIM1,
    REG_BORDER_DIM2
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_W-1:0] out_coord0;
    logic [COORD_W-1:0] out_coord1;
    logic [COORD_W-1:0] out_coord2;
  } req_t;

  typedef struct packed {
    logic [SRC_W-1:0] src_coord0;
    logic [SRC_W-1:0] src_coord1;
    logic [SRC_W-1:0] src_coord2;
    logic             is_zero_fill;
  } rsp_t;

  typedef struct packed {
    mode_t                              mode;
    logic [DIM_SLOTS-1:0][EXT_W-1:0]    size;
    logic [DIM_SLOTS-1:0][BORDER_W-1:0] border;
  } cfg_t;

  typedef logic [DIM_SLOTS-1:0][POS_W-1:0] pos_vec_t;

  typedef struct packed {
    logic                            flag;
    logic [DIM_SLOTS-1:0]            neg;
    logic [DIM_SLOTS-1:0][MAG_W-1:0] mag;
  } pipe_t;

  function automatic logic [EXT_W-1:0] eff_size(input logic [SIZE_W-1:0] raw);
    logic [31:0] w;
    w = 32'(raw);
    if (w == 32'd0) w = 32'd1;
    if (w > 32'(MAX_EXTENT)) w = 32'(MAX_EXTENT);
    return w[EXT_W-1:0];
  endfunction

endpackage

@@ rtl/tbim_cfg_regs.sv @@
// Configuration register file for the border index map.
// Holds the border mode, clamped extents and border widths; uses tbim_pkg.
`timescale 1ns / 1ps

module tbim_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tbim_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tbim_pkg::CFG_DATA_W-1:0] cfg_data,
  output tbim_pkg::cfg_t                  cfg
);
  import tbim_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode <= MODE_ZERO;
      for (int d = 0; d < DIM_SLOTS; d++) begin
        cfg.size[d]   <= eff_size(SIZE_W'(1));
        cfg.border[d] <= '0;
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BORDER_MODE: cfg.mode      <= mode_t'(cfg_data[MODE_W-1:0]);
        REG_SIZE_DIM0:   cfg.size[0]   <= eff_size(cfg_data[SIZE_W-1:0]);
        REG_SIZE_DIM1:   cfg.size[1]   <= eff_size(cfg_data[SIZE_W-1:0]);
        REG_SIZE_DIM2:   cfg.size[2]   <= eff_size(cfg_data[SIZE_W-1:0]);
        REG_BORDER_DIM0: cfg.border[0] <= cfg_data[BORDER_W-1:0];
        REG_BORDER_DIM1: cfg.border[1] <= cfg_data[BORDER_W-1:0];
        REG_BORDER_DIM2: cfg.border[2] <= cfg_data[BORDER_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

@@ rtl/tbim_front.sv @@
// Front two pipeline stages: border subtraction, then mode decode into a
// sign and magnitude ready for the remainder pipeline. Uses tbim_pkg.
`timescale 1ns / 1ps

module tbim_front (
  input  logic            clk,
  input  logic            rst,
  input  tbim_pkg::cfg_t  cfg,
  input  logic            req_valid,
  output logic            req_ready,
  input  tbim_pkg::req_t  req,
  output logic            out_valid,
  input  logic            out_ready,
  output tbim_pkg::pipe_t out_data
);
  import tbim_pkg::*;

  localparam logic signed [VAL_W-1:0] VAL_ONE = VAL_W'(1);

  logic                 a_valid;
  pos_vec_t             a_pos;
  pos_vec_t             a_pos_next;
  logic                 a_ready;
  logic                 b_valid;
  pipe_t                b_data;
  pipe_t                b_data_next;
  logic                 b_ready;
  logic [COORD_W-1:0]   coord [DIM_SLOTS];
  logic [DIM_SLOTS-1:0] flag_v;

  assign coord[0] = req.out_coord0;
  assign coord[1] = req.out_coord1;
  assign coord[2] = req.out_coord2;

  assign b_ready   = !b_valid || out_ready;
  assign a_ready   = !a_valid || b_ready;
  assign req_ready = a_ready;
  assign out_valid = b_valid;
  assign out_data  = b_data;

  for (genvar d = 0; d < DIM_SLOTS; d++) begin : g_dim
    if (d < NUM_DIMS) begin : g_act
      logic signed [VAL_W-1:0] pos_s;
      logic signed [VAL_W-1:0] n_s;
      logic signed [VAL_W-1:0] pos_neg;
      logic signed [VAL_W-1:0] refl;
      logic signed [VAL_W-1:0] refl_neg;
      logic                    below;
      logic                    above;

      assign a_pos_next[d] = POS_W'($signed(POS_W'(coord[d])) -
                                    $signed(POS_W'(cfg.border[d])));

      assign pos_s    = VAL_W'($signed(a_pos[d]));
      assign n_s      = $signed(VAL_W'(cfg.size[d]));
      assign below    = pos_s[VAL_W-1];
      assign above    = pos_s >= n_s;
      assign pos_neg  = -pos_s;
      assign refl     = (n_s <<< 1) - pos_s - VAL_ONE;
      assign refl_neg = pos_s - (n_s <<< 1) + VAL_ONE;

      always_comb begin
        flag_v[d]             = 1'b0;
        b_data_next.neg[d]    = 1'b0;
        b_data_next.mag[d]    = MAG_W'(a_pos[d]);
        case (cfg.mode)
          MODE_ZERO: begin
            if (below || above) begin
              flag_v[d]          = 1'b1;
              b_data_next.mag[d] = '0;
            end
          end
          MODE_CYCLIC: begin
            if (below) begin
              b_data_next.neg[d] = 1'b1;
              b_data_next.mag[d] = MAG_W'(pos_neg);
            end
          end
          MODE_REPLICATE: begin
            if (below) begin
              b_data_next.mag[d] = '0;
            end else if (above) begin
              b_data_next.mag[d] = MAG_W'(n_s - VAL_ONE);
            end
          end
          MODE_REFLECT: begin
            if (below) begin
              b_data_next.mag[d] = MAG_W'(pos_neg);
            end else if (above) begin
              if (refl[VAL_W-1]) begin
                b_data_next.neg[d] = 1'b1;
                b_data_next.mag[d] = MAG_W'(refl_neg);
              end else begin
                b_data_next.mag[d] = MAG_W'(refl);
              end
            end
          end
          default: begin
          end
        endcase
      end
    end else begin : g_idle
      assign a_pos_next[d]      = '0;
      assign flag_v[d]          = 1'b0;
      assign b_data_next.neg[d] = 1'b0;
      assign b_data_next.mag[d] = '0;
    end
  end

  assign b_data_next.flag = |flag_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (a_ready) a_valid <= req_valid;
      if (b_ready) b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && a_ready) a_pos <= a_pos_next;
    if (a_valid && b_ready) b_data <= b_data_next;
  end

endmodule

@@ rtl/tbim_rem_pipe.sv @@
// Remainder pipeline: one conditional subtract of the shifted extent per
// stage, quotient bit by quotient bit from the top. Uses tbim_pkg.
`timescale 1ns / 1ps

module tbim_rem_pipe (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic [tbim_pkg::DIM_SLOTS-1:0][tbim_pkg::EXT_W-1:0] size,
  input  logic                                          in_valid,
  output logic                                          in_ready,
  input  tbim_pkg::pipe_t                               in_data,
  output logic                                          out_valid,
  input  logic                                          out_ready,
  output tbim_pkg::pipe_t                               out_data
);
  import tbim_pkg::*;

  logic  vld [STEPS];
  pipe_t dat [STEPS];
  logic  rdy [STEPS];

  assign in_ready  = rdy[0];
  assign out_valid = vld[STEPS-1];
  assign out_data  = dat[STEPS-1];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam int K = STEPS - 1 - i;
    logic  src_v;
    pipe_t src_d;
    pipe_t step_next;

    if (i == 0) begin : g_first
      assign src_v = in_valid;
      assign src_d = in_data;
    end else begin : g_mid
      assign src_v = vld[i-1];
      assign src_d = dat[i-1];
    end

    if (i == STEPS - 1) begin : g_last
      assign rdy[i] = !vld[i] || out_ready;
    end else begin : g_chain
      assign rdy[i] = !vld[i] || rdy[i+1];
    end

    always_comb begin
      logic [REM_W-1:0] dv;
      logic [REM_W-1:0] r;
      step_next = src_d;
      for (int d = 0; d < DIM_SLOTS; d++) begin
        dv = REM_W'(size[d]) << K;
        r  = REM_W'(src_d.mag[d]);
        if (r >= dv) begin
          step_next.mag[d] = MAG_W'(r - dv);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (rdy[i]) begin
        vld[i] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (src_v && rdy[i]) dat[i] <= step_next;
    end
  end

endmodule

@@ rtl/tbim_back.sv @@
// Output stage: turns a remainder of a negative value into its non-negative
// wrap, applies the zero-fill flag and registers the result. Uses tbim_pkg.
`timescale 1ns / 1ps

module tbim_back (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic [tbim_pkg::DIM_SLOTS-1:0][tbim_pkg::EXT_W-1:0] size,
  input  logic                                          in_valid,
  output logic                                          in_ready,
  input  tbim_pkg::pipe_t                               in_data,
  output logic                                          rsp_valid,
  input  logic                                          rsp_ready,
  output tbim_pkg::rsp_t                                rsp
);
  import tbim_pkg::*;

  logic [SRC_W-1:0] src [DIM_SLOTS];
  rsp_t             rsp_next;

  assign in_ready = !rsp_valid || rsp_ready;

  for (genvar d = 0; d < DIM_SLOTS; d++) begin : g_dim
    if (d < NUM_DIMS) begin : g_act
      logic [CORR_W-1:0] corr;
      logic [CORR_W-1:0] res;
      assign corr = CORR_W'(size[d]) - CORR_W'(in_data.mag[d]);
      assign res  = (in_data.neg[d] && (in_data.mag[d] != '0)) ? corr
                                                               : CORR_W'(in_data.mag[d]);
      assign src[d] = in_data.flag ? '0 : SRC_W'(res);
    end else begin : g_idle
      assign src[d] = '0;
    end
  end

  assign rsp_next.src_coord0   = src[0];
  assign rsp_next.src_coord1   = src[1];
  assign rsp_next.src_coord2   = src[2];
  assign rsp_next.is_zero_fill = in_data.flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (in_ready) begin
      rsp_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) rsp <= rsp_next;
  end

endmodule

@@ rtl/tensor_border_index_map.sv @@
// A request passes the front stages, the 14-stage remainder pipeline (one
// quotient bit per stage; it sets the depth) and the output register. One
// transaction per cycle while rsp_ready is high; every stage can stall alone.
// Reset (synchronous) empties the pipeline and sets zero mode, extents of 1
// and border widths of 0. Configuration writes are taken in every cycle.
// Top level; instantiates tbim_cfg_regs, tbim_front, tbim_rem_pipe, tbim_back.
`timescale 1ns / 1ps

module tensor_border_index_map (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tbim_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tbim_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            req_valid,
  output logic                            req_ready,
  input  tbim_pkg::req_t                  req,
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output tbim_pkg::rsp_t                  rsp
);
  import tbim_pkg::*;

  cfg_t  cfg;
  logic  f_valid;
  logic  f_ready;
  pipe_t f_data;
  logic  r_valid;
  logic  r_ready;
  pipe_t r_data;

  tbim_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tbim_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_data  (f_data)
  );

  tbim_rem_pipe u_rem (
    .clk       (clk),
    .rst       (rst),
    .size      (cfg.size),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_data),
    .out_valid (r_valid),
    .out_ready (r_ready),
    .out_data  (r_data)
  );

  tbim_back u_back (
    .clk       (clk),
    .rst       (rst),
    .size      (cfg.size),
    .in_valid  (r_valid),
    .in_ready  (r_ready),
    .in_data   (r_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

@@ verif/tensor_border_index_map_tb.sv @@
// Self-checking testbench for tensor_border_index_map: random and directed coordinates under
// every border mode, checked against a behavioral prediction of the source coordinates.
// Depends on tbim_pkg and the tensor_border_index_map RTL only.
`timescale 1ns / 1ps

module tensor_border_index_map_tb;
  import tbim_pkg::*;

  localparam int COORD_MAX     = (1 << COORD_W) - 1;
  localparam int DATA_MAX      = (1 << CFG_DATA_W) - 1;
  localparam int PHASES        = 24;
  localparam int PHASE_ITEMS   = 75;
  localparam int PRESSURE_PH   = 6;
  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 40;
  localparam cfg_reg_t REG_UNMAPPED = cfg_reg_t'(REG_BORDER_DIM2 + 1);

  typedef struct {
    cfg_reg_t              index;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  req_valid = 1'b0;
  logic                  req_ready;
  req_t                  req = '0;
  logic                  rsp_valid;
  logic                  rsp_ready = 1'b0;
  rsp_t                  rsp;

  mode_t              mode_reg = MODE_ZERO;
  logic [SIZE_W-1:0]  size_reg[DIM_SLOTS] = '{default: 1};
  logic [BORDER_W-1:0] border_reg[DIM_SLOTS] = '{default: 0};

  req_t coords_to_send[$];
  rsp_t predicted_src[$];
  rsp_t want;
  int   errors = 0;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   hold_trigger = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  int   quiet_cycles = 0;

  tensor_border_index_map dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int extent(input int d);
    int n;
    n = int'(size_reg[d]);
    if (n == 0) n = 1;
    if (n > MAX_EXTENT) n = MAX_EXTENT;
    return n;
  endfunction

  function automatic rsp_t map_to_source(input req_t r);
    int          n;
    int          pos;
    int          d;
    logic [COORD_W-1:0] coord[DIM_SLOTS];
    logic [SRC_W-1:0]   src[DIM_SLOTS];
    logic        outside;
    rsp_t        res;
    coord[0] = r.out_coord0;
    coord[1] = r.out_coord1;
    coord[2] = r.out_coord2;
    src = '{default: '0};
    outside = 1'b0;
    for (d = 0; d < DIM_SLOTS && d < NUM_DIMS; d++) begin
      n = extent(d);
      pos = int'(coord[d]) - int'(border_reg[d]);
      case (mode_reg)
        MODE_ZERO: begin
          if (pos < 0 || pos >= n) outside = 1'b1;
        end
        MODE_CYCLIC: begin
          pos = pos % n;
          if (pos < 0) pos += n;
        end
        MODE_REPLICATE: begin
          if (pos < 0) pos = 0;
          else if (pos >= n) pos = n - 1;
        end
        default: begin
          if (pos < 0) pos = -pos;
          else if (pos >= n) pos = 2 * n - pos - 1;
          pos = pos % n;
          if (pos < 0) pos += n;
        end
      endcase
      src[d] = SRC_W'(pos);
    end
    res.src_coord0   = outside ? '0 : src[0];
    res.src_coord1   = outside ? '0 : src[1];
    res.src_coord2   = outside ? '0 : src[2];
    res.is_zero_fill = outside;
    return res;
  endfunction

  function automatic req_t random_coords();
    int   d;
    int   n;
    int   b;
    int   v;
    logic [COORD_W-1:0] c[DIM_SLOTS];
    req_t r;
    for (d = 0; d < DIM_SLOTS; d++) begin
      n = extent(d);
      b = int'(border_reg[d]);
      case ($urandom_range(7))
        0:       v = $urandom_range(COORD_MAX);
        1, 2, 3: v = b + $urandom_range(n - 1);
        default: v = b - 2 * n - 2 + $urandom_range(4 * n + 4);
      endcase
      if (v < 0) v = 0;
      if (v > COORD_MAX) v = COORD_MAX;
      c[d] = COORD_W'(v);
    end
    r.out_coord0 = c[0];
    r.out_coord1 = c[1];
    r.out_coord2 = c[2];
    return r;
  endfunction

  // The block counts as idle only when it looks idle at successive edges, so that a
  // transaction popped by the driver at the same edge is never missed.
  task automatic wait_idle();
    int idle_edges;
    idle_edges = 0;
    while (idle_edges < 2) begin
      @(posedge clk);
      if (coords_to_send.size() == 0 && !req_valid && predicted_src.size() == 0) begin
        idle_edges++;
      end else begin
        idle_edges = 0;
      end
    end
  endtask

  task automatic program_regs(input reg_write_t writes[$]);
    foreach (writes[i]) begin
      cfg_valid <= 1'b1;
      cfg_index <= writes[i].index;
      cfg_data  <= writes[i].data;
      do @(posedge clk);
      while (!cfg_ready);
      case (writes[i].index)
        REG_BORDER_MODE: mode_reg = mode_t'(writes[i].data[MODE_W-1:0]);
        REG_SIZE_DIM0:   size_reg[0] = writes[i].data;
        REG_SIZE_DIM1:   size_reg[1] = writes[i].data;
        REG_SIZE_DIM2:   size_reg[2] = writes[i].data;
        REG_BORDER_DIM0: border_reg[0] = writes[i].data[BORDER_W-1:0];
        REG_BORDER_DIM1: border_reg[1] = writes[i].data[BORDER_W-1:0];
        REG_BORDER_DIM2: border_reg[2] = writes[i].data[BORDER_W-1:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Request driver: payload holds until the transaction completes.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        predicted_src.push_back(map_to_source(req));
      end
      if (!req_valid || req_ready) begin
        if (coords_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req       <= coords_to_send.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_trigger != hold_seen) begin
      hold_seen = hold_trigger;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (predicted_src.size() == 0) begin
        $display("%0t: unexpected response, expected none, actual %p", $time, rsp);
        errors++;
      end else begin
        want = predicted_src.pop_front();
        if (rsp.src_coord0 !== want.src_coord0) begin
          $display("%0t: src_coord0 expected %0d actual %0d", $time, want.src_coord0,
                   rsp.src_coord0);
          errors++;
        end
        if (rsp.src_coord1 !== want.src_coord1) begin
          $display("%0t: src_coord1 expected %0d actual %0d", $time, want.src_coord1,
                   rsp.src_coord1);
          errors++;
        end
        if (rsp.src_coord2 !== want.src_coord2) begin
          $display("%0t: src_coord2 expected %0d actual %0d", $time, want.src_coord2,
                   rsp.src_coord2);
          errors++;
        end
        if (rsp.is_zero_fill !== want.is_zero_fill) begin
          $display("%0t: is_zero_fill expected %0b actual %0b", $time, want.is_zero_fill,
                   rsp.is_zero_fill);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("tensor_border_index_map_tb: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    reg_write_t writes[$];
    mode_t      dir_modes[3] = '{MODE_CYCLIC, MODE_REPLICATE, MODE_REFLECT};
    req_t       dir_items[5] = '{
      '{14'd4095, 14'd0,     14'd5},
      '{14'd4094, 14'd4095,  14'd4100},
      '{14'd4096, 14'd4096,  14'd4},
      '{14'd0,    14'd16383, 14'd0},
      '{14'd16383, 14'd8191, 14'd4101}
    };
    int p;
    int i;
    int d;
    int sz;
    int bd;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: unit extents, no border, zero mode.
    coords_to_send.push_back('{14'd0, 14'd0, 14'd0});
    coords_to_send.push_back('{14'd1, 14'd0, 14'd0});
    coords_to_send.push_back('{14'd0, 14'd0, 14'd16383});
    wait_idle();

    // Zero extent, maximum extent and oversized extent, with masked upper data bits.
    writes.delete();
    writes.push_back('{REG_BORDER_MODE, {11'h7FF, MODE_ZERO}});
    writes.push_back('{REG_SIZE_DIM0, 13'd0});
    writes.push_back('{REG_SIZE_DIM1, 13'd4096});
    writes.push_back('{REG_SIZE_DIM2, 13'd8191});
    writes.push_back('{REG_BORDER_DIM0, 13'h1FFF});
    writes.push_back('{REG_BORDER_DIM1, 13'h1000});
    writes.push_back('{REG_BORDER_DIM2, 13'd5});
    writes.push_back('{REG_UNMAPPED, 13'h1FFF});
    program_regs(writes);
    foreach (dir_items[j]) coords_to_send.push_back(dir_items[j]);
    wait_idle();
    foreach (dir_modes[m]) begin
      writes.delete();
      writes.push_back('{REG_BORDER_MODE, {11'h7FF, dir_modes[m]}});
      program_regs(writes);
      foreach (dir_items[j]) coords_to_send.push_back(dir_items[j]);
      wait_idle();
    end

    for (p = 0; p < PHASES; p++) begin
      writes.delete();
      writes.push_back('{REG_BORDER_MODE, {11'($urandom), 2'($urandom_range(3))}});
      for (d = 0; d < DIM_SLOTS; d++) begin
        if (p == 0) begin
          sz = ($urandom_range(1) == 0) ? MAX_EXTENT : DATA_MAX;
          bd = (1 << BORDER_W) - 1;
        end else if (p == 1) begin
          sz = 1;
          bd = 0;
        end else begin
          case ($urandom_range(9))
            0:       sz = 0;
            1:       sz = 1;
            2:       sz = MAX_EXTENT;
            3:       sz = $urandom_range(DATA_MAX, MAX_EXTENT + 1);
            4, 5:    sz = $urandom_range(MAX_EXTENT - 1, 2);
            default: sz = $urandom_range(16, 1);
          endcase
          case ($urandom_range(7))
            0:       bd = 0;
            1:       bd = (1 << BORDER_W) - 1;
            2:       bd = $urandom_range((1 << BORDER_W) - 1);
            default: bd = $urandom_range(20);
          endcase
        end
        writes.push_back('{cfg_reg_t'(REG_SIZE_DIM0 + d), CFG_DATA_W'(sz)});
        writes.push_back('{cfg_reg_t'(REG_BORDER_DIM0 + d),
                           {1'($urandom), BORDER_W'(bd)}});
      end
      if ($urandom_range(3) == 0) writes.push_back('{REG_UNMAPPED, 13'($urandom)});
      program_regs(writes);

      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 49; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 49; end
        default: begin send_idle_pct = 25; stall_pct = 25; end
      endcase
      if (p == PRESSURE_PH) begin
        send_idle_pct = 0;
        stall_pct = 0;
      end
      for (i = 0; i < PHASE_ITEMS; i++) coords_to_send.push_back(random_coords());
      if (p == PRESSURE_PH) hold_trigger = hold_trigger + 1;
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && predicted_src.size() == 0) begin
      $display("tensor_border_index_map_tb: PASS");
    end else begin
      $display("tensor_border_index_map_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/tbim_pkg.sv
rtl/tbim_cfg_regs.sv
rtl/tbim_front.sv
rtl/tbim_rem_pipe.sv
rtl/tbim_back.sv
rtl/tensor_border_index_map.sv
verif/tensor_border_index_map_tb.sv
